### hw/rtl/rdp_pkg.sv
// ============================================================================
// rdp_pkg
// Shared types, constants and coil pattern lookup for the dot printer
// sequencer.
// ============================================================================
package rdp_pkg;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // motion constants
    localparam logic [10:0] LOAD_FEED_STEPS    = 11'd100;
    localparam logic [10:0] FEED_STEPS_PER_ROW = 11'd3;
    localparam logic [14:0] PAPER_HOLD_US      = 15'd4000;

    // result action codes
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_RIGHT   = 3'd1;
    localparam logic [2:0] ACT_LEFT    = 3'd2;
    localparam logic [2:0] ACT_PAPER   = 3'd3;
    localparam logic [2:0] ACT_FIRE    = 3'd4;
    localparam logic [2:0] ACT_RELEASE = 3'd5;
    localparam logic [2:0] ACT_DONE    = 3'd6;

    // live configuration
    typedef struct packed {
        logic [7:0]  width_bytes;
        logic [11:0] height_rows;
        logic [14:0] right_step_us;
        logic [14:0] left_step_us;
        logic [11:0] write_pulse_us;
    } t_cfg;

    // one queued job for the back end: either a finished single result
    // or a pixel byte to be expanded
    typedef struct packed {
        logic        is_byte;
        logic [2:0]  action;
        logic [3:0]  head_coils;
        logic [3:0]  paper_coils;
        logic [14:0] hold_us;
        logic        refused;
        logic        need_byte;
        logic [7:0]  pixel;
        logic [2:0]  head_phase;
    } t_qentry;

    // half-step head coil patterns
    function automatic logic [3:0] head_pattern(input logic [2:0] ph);
        logic [3:0] pat;
        unique case (ph)
            3'd0:    pat = 4'd1;
            3'd1:    pat = 4'd3;
            3'd2:    pat = 4'd2;
            3'd3:    pat = 4'd6;
            3'd4:    pat = 4'd4;
            3'd5:    pat = 4'd12;
            3'd6:    pat = 4'd8;
            default: pat = 4'd9;
        endcase
        return pat;
    endfunction

endpackage

### hw/rtl/raster_dot_printer_sequencer.sv
// ============================================================================
// raster_dot_printer_sequencer
// Dot printer engine sequencer: job control, half-step head and wave-drive
// paper motor phases, pixel byte expansion into pen and head actions.
// ============================================================================
// Usage:
// - input channel (i_valid / o_stall): items with i_kind (start, pixel byte,
//   advance, abort) and i_pixel_byte; accepted when i_valid and !o_stall
// - output channel (o_valid / i_stall): one result per accepted transfer;
//   o_last marks the final result of an item
// - config channel (i_cfg_valid / o_cfg_ready): register index and data;
//   ready is always high, writes to unused indexes are dropped
// - an item is classified in the cycle it is accepted and queued; its first
//   result passes through the queue entry and then the output register
//   before it shows on the output
// - start, advance, abort and refused items give one result each and flow at
//   one item per cycle while nothing stalls; a pixel byte gives 8 to 16
//   results, one per cycle while the output is not stalled, set by the
//   back-end expansion counter (8 right steps plus one fire per set bit)
// - o_stall rises only when the job queue is full; a stalled output holds
//   its result and the queue absorbs new items until it fills
// - reset clears the job, queue and output; head phase starts at the last
//   half step, paper phase at zero, registers at their defaults
// ============================================================================
module raster_dot_printer_sequencer
    import rdp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_pixel_byte,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_action,
    output logic [3:0]  o_head_coils,
    output logic [3:0]  o_paper_coils,
    output logic        o_fire,
    output logic [14:0] o_hold_us,
    output logic        o_need_byte,
    output logic        o_refused,
    output logic        o_last,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    // register indexes
    localparam logic [2:0] CFG_WIDTH_BYTES    = 3'd0;
    localparam logic [2:0] CFG_HEIGHT_ROWS    = 3'd1;
    localparam logic [2:0] CFG_RIGHT_STEP_US  = 3'd2;
    localparam logic [2:0] CFG_LEFT_STEP_US   = 3'd3;
    localparam logic [2:0] CFG_WRITE_PULSE_US = 3'd4;

    t_cfg    r_cfg;
    logic    w_accept;
    logic    w_q_full;
    logic    w_q_nonempty;
    logic    w_q_pop;
    t_qentry w_push_entry;
    t_qentry w_head_entry;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = w_q_full;
    assign w_accept    = i_valid && !w_q_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_bytes    <= 8'd0;
            r_cfg.height_rows    <= 12'd0;
            r_cfg.right_step_us  <= 15'd3000;
            r_cfg.left_step_us   <= 15'd1800;
            r_cfg.write_pulse_us <= 12'd40;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WIDTH_BYTES:    r_cfg.width_bytes    <= i_cfg_data[7:0];
                CFG_HEIGHT_ROWS:    r_cfg.height_rows    <= i_cfg_data[11:0];
                CFG_RIGHT_STEP_US:  r_cfg.right_step_us  <= i_cfg_data;
                CFG_LEFT_STEP_US:   r_cfg.left_step_us   <= i_cfg_data;
                CFG_WRITE_PULSE_US: r_cfg.write_pulse_us <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // front: job control
    rdp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (w_accept),
        .i_kind       (i_kind),
        .i_pixel_byte (i_pixel_byte),
        .o_entry      (w_push_entry)
    );

    // job queue
    rdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_accept),
        .i_data     (w_push_entry),
        .i_pop      (w_q_pop),
        .o_full     (w_q_full),
        .o_nonempty (w_q_nonempty),
        .o_data     (w_head_entry)
    );

    // back: result expansion and output register
    rdp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_nonempty  (w_q_nonempty),
        .i_q_data      (w_head_entry),
        .o_q_pop       (w_q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_action      (o_action),
        .o_head_coils  (o_head_coils),
        .o_paper_coils (o_paper_coils),
        .o_fire        (o_fire),
        .o_hold_us     (o_hold_us),
        .o_need_byte   (o_need_byte),
        .o_refused     (o_refused),
        .o_last        (o_last)
    );

endmodule

### hw/rtl/rdp_queue.sv
// ============================================================================
// rdp_queue
// Small first-in first-out queue of jobs between the front and back ends.
// ============================================================================
module rdp_queue
    import rdp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_qentry i_data,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_nonempty,
    output t_qentry o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_qentry       r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    assign o_full     = (r_count == FULL_CNT);
    assign o_nonempty = (r_count != '0);
    assign o_data     = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hw/rtl/rdp_front.sv
// ============================================================================
// rdp_front
// Accepts items, runs the job state machine and motor phase tracking, and
// queues one job per item for the back end.
// ============================================================================
module rdp_front
    import rdp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_pixel_byte,
    output t_qentry    o_entry
);

    // job phase codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_LOAD     = 3'd1;
    localparam logic [2:0] PH_SWEEP_R  = 3'd2;
    localparam logic [2:0] PH_SWEEP_L  = 3'd3;
    localparam logic [2:0] PH_ROW_FEED = 3'd4;
    localparam logic [2:0] PH_BYTES    = 3'd5;
    localparam logic [2:0] PH_RETURN   = 3'd6;
    localparam logic [2:0] PH_FINISH   = 3'd7;

    // item kinds
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_PIXEL   = 2'd1;
    localparam logic [1:0] KIND_ADVANCE = 2'd2;
    localparam logic [1:0] KIND_ABORT   = 2'd3;

    typedef struct packed {
        logic [2:0]  phase;
        logic [10:0] moves;
        logic        rel;
        logic        clr_bytes;
    } t_enter;

    // phase entry, following the fall-through of empty sweeps and rows
    function automatic t_enter enter_phase(input logic [2:0]  ph,
                                           input logic [10:0] span,
                                           input logic        width_zero,
                                           input logic        rows_reached);
        t_enter e;
        e.phase     = ph;
        e.moves     = '0;
        e.rel       = 1'b0;
        e.clr_bytes = 1'b0;
        unique case (ph)
            PH_LOAD: begin
                e.moves = LOAD_FEED_STEPS;
            end
            PH_SWEEP_R: begin
                if (span == '0) begin
                    e.phase = PH_SWEEP_L;
                    e.rel   = 1'b1;
                end else begin
                    e.moves = span;
                end
            end
            PH_SWEEP_L, PH_RETURN: begin
                e.moves = span;
                e.rel   = (span == '0);
            end
            PH_ROW_FEED: begin
                if (rows_reached) begin
                    e.phase = PH_FINISH;
                end else begin
                    e.moves = FEED_STEPS_PER_ROW;
                end
            end
            PH_BYTES: begin
                e.clr_bytes = 1'b1;
                if (width_zero) begin
                    e.phase = PH_RETURN;
                    e.rel   = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return e;
    endfunction

    logic [2:0]  r_phase,      n_phase;
    logic [10:0] r_moves,      n_moves;
    logic [7:0]  r_bytes,      n_bytes;
    logic [11:0] r_rows,       n_rows;
    logic [2:0]  r_head_phase, n_head_phase;
    logic [1:0]  r_paper_phase, n_paper_phase;
    logic        r_rel,        n_rel;
    logic        r_head_on,    n_head_on;
    logic        r_paper_on,   n_paper_on;

    logic        w_use_enter;
    logic [2:0]  w_target;
    t_enter      w_enter;
    logic [10:0] w_span;
    logic [7:0]  w_bytes_inc;
    logic [10:0] w_moves_dec;
    logic        w_paper_phase_kind;
    logic [1:0]  w_paper_idx;

    assign w_span             = {i_cfg.width_bytes, 3'b000};
    assign w_bytes_inc        = r_bytes + 8'd1;
    assign w_moves_dec        = (r_moves != '0) ? r_moves - 11'd1 : '0;
    assign w_paper_phase_kind = (r_phase == PH_LOAD) || (r_phase == PH_ROW_FEED);

    // next state and queued job
    always_comb begin
        n_phase       = r_phase;
        n_moves       = r_moves;
        n_bytes       = r_bytes;
        n_rows        = r_rows;
        n_head_phase  = r_head_phase;
        n_paper_phase = r_paper_phase;
        n_rel         = r_rel;
        n_head_on     = r_head_on;
        n_paper_on    = r_paper_on;
        w_use_enter   = 1'b0;
        w_target      = PH_IDLE;
        w_enter       = '0;
        w_paper_idx   = '0;

        o_entry            = '0;
        o_entry.action     = ACT_NONE;
        o_entry.pixel      = i_pixel_byte;
        o_entry.head_phase = r_head_phase;

        priority if (i_kind == KIND_START && r_phase == PH_IDLE) begin
            n_bytes     = '0;
            n_rows      = '0;
            w_use_enter = 1'b1;
            w_target    = PH_LOAD;
        end else if (i_kind == KIND_PIXEL && r_phase == PH_BYTES) begin
            // the byte ends with a right step, so the head is on afterwards
            o_entry.is_byte = 1'b1;
            n_head_on       = 1'b1;
            n_bytes         = w_bytes_inc;
            if (w_bytes_inc >= i_cfg.width_bytes || w_bytes_inc == '0) begin
                w_use_enter = 1'b1;
                w_target    = PH_RETURN;
            end
        end else if (i_kind == KIND_ADVANCE && r_phase != PH_IDLE &&
                     r_phase != PH_BYTES) begin
            priority if (r_phase == PH_FINISH) begin
                n_head_on      = 1'b0;
                n_paper_on     = 1'b0;
                n_phase        = PH_IDLE;
                n_moves        = '0;
                n_bytes        = '0;
                n_rows         = '0;
                n_rel          = 1'b0;
                o_entry.action = ACT_DONE;
            end else if (r_phase == PH_SWEEP_R) begin
                n_head_phase    = r_head_phase + 3'd1;
                n_head_on       = 1'b1;
                o_entry.action  = ACT_RIGHT;
                o_entry.hold_us = i_cfg.right_step_us;
                n_moves         = w_moves_dec;
                if (w_moves_dec == '0) begin
                    w_use_enter = 1'b1;
                    w_target    = PH_SWEEP_L;
                end
            end else if (r_rel || r_moves == '0) begin
                // end of a move: drop the coils of the motor that moved
                if (w_paper_phase_kind) begin
                    n_paper_on = 1'b0;
                end else begin
                    n_head_on = 1'b0;
                end
                o_entry.action = ACT_RELEASE;
                w_use_enter    = 1'b1;
                priority if (r_phase == PH_LOAD) begin
                    w_target = PH_SWEEP_R;
                end else if (r_phase == PH_SWEEP_L) begin
                    w_target = PH_ROW_FEED;
                end else if (r_phase == PH_ROW_FEED) begin
                    w_target = PH_BYTES;
                end else begin
                    n_rows   = r_rows + 12'd1;
                    w_target = PH_ROW_FEED;
                end
            end else begin
                if (w_paper_phase_kind) begin
                    n_paper_phase   = r_paper_phase + 2'd1;
                    n_paper_on      = 1'b1;
                    o_entry.action  = ACT_PAPER;
                    o_entry.hold_us = PAPER_HOLD_US;
                end else begin
                    n_head_phase    = r_head_phase - 3'd1;
                    n_head_on       = 1'b1;
                    o_entry.action  = ACT_LEFT;
                    o_entry.hold_us = i_cfg.left_step_us;
                end
                n_moves = r_moves - 11'd1;
                if (n_moves == '0) begin
                    n_rel = 1'b1;
                end
            end
        end else if (i_kind == KIND_ABORT && r_phase != PH_IDLE) begin
            n_head_on      = 1'b0;
            n_paper_on     = 1'b0;
            n_phase        = PH_IDLE;
            n_moves        = '0;
            n_bytes        = '0;
            n_rows         = '0;
            n_rel          = 1'b0;
            o_entry.action = ACT_DONE;
        end else begin
            o_entry.refused = 1'b1;
        end

        // phase entry uses the updated row count
        if (w_use_enter) begin
            w_enter = enter_phase(w_target, w_span, (i_cfg.width_bytes == '0),
                                  (n_rows >= i_cfg.height_rows));
            n_phase = w_enter.phase;
            n_moves = w_enter.moves;
            n_rel   = w_enter.rel;
            if (w_enter.clr_bytes) begin
                n_bytes = '0;
            end
        end

        // coil levels after the item
        w_paper_idx         = n_paper_phase - 2'd1;
        o_entry.head_coils  = n_head_on ? head_pattern(n_head_phase) : 4'd0;
        o_entry.paper_coils = n_paper_on ? (4'd1 << w_paper_idx) : 4'd0;
        o_entry.need_byte   = (n_phase == PH_BYTES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_moves       <= '0;
            r_bytes       <= '0;
            r_rows        <= '0;
            r_head_phase  <= 3'd7;
            r_paper_phase <= '0;
            r_rel         <= 1'b0;
            r_head_on     <= 1'b0;
            r_paper_on    <= 1'b0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_moves       <= n_moves;
            r_bytes       <= n_bytes;
            r_rows        <= n_rows;
            r_head_phase  <= n_head_phase;
            r_paper_phase <= n_paper_phase;
            r_rel         <= n_rel;
            r_head_on     <= n_head_on;
            r_paper_on    <= n_paper_on;
        end
    end

endmodule

### hw/rtl/rdp_back.sv
// ============================================================================
// rdp_back
// Takes queued jobs and drives the output register, expanding a pixel byte
// into its fire and right step results one per cycle while not stalled.
// ============================================================================
module rdp_back
    import rdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_nonempty,
    input  t_qentry     i_q_data,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_action,
    output logic [3:0]  o_head_coils,
    output logic [3:0]  o_paper_coils,
    output logic        o_fire,
    output logic [14:0] o_hold_us,
    output logic        o_need_byte,
    output logic        o_refused,
    output logic        o_last
);

    logic        r_valid;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_fired, n_fired;
    logic [2:0]  r_action, n_action;
    logic [3:0]  r_head_coils, n_head_coils;
    logic [3:0]  r_paper_coils, n_paper_coils;
    logic        r_fire, n_fire;
    logic [14:0] r_hold_us, n_hold_us;
    logic        r_need_byte, n_need_byte;
    logic        r_refused, n_refused;
    logic        r_last, n_last;

    logic        w_load;
    logic        w_bit;
    logic        w_fire_now;

    assign w_load     = !r_valid || !i_stall;
    assign w_bit      = i_q_data.pixel[3'd7 - r_cnt];
    assign w_fire_now = i_q_data.is_byte && w_bit && !r_fired;
    assign o_q_pop    = w_load && i_q_nonempty && n_last;

    // next result from the queue head
    always_comb begin
        n_cnt         = r_cnt;
        n_fired       = r_fired;
        n_action      = i_q_data.action;
        n_head_coils  = i_q_data.head_coils;
        n_paper_coils = i_q_data.paper_coils;
        n_fire        = (i_q_data.action == ACT_FIRE);
        n_hold_us     = i_q_data.hold_us;
        n_need_byte   = i_q_data.need_byte;
        n_refused     = i_q_data.refused;
        n_last        = 1'b1;
        if (i_q_data.is_byte) begin
            if (w_fire_now) begin
                // pen fires with the head coils off
                n_action     = ACT_FIRE;
                n_head_coils = 4'd0;
                n_fire       = 1'b1;
                n_hold_us    = {3'b000, i_cfg.write_pulse_us};
                n_last       = 1'b0;
                n_fired      = 1'b1;
            end else begin
                n_action     = ACT_RIGHT;
                n_head_coils = head_pattern(i_q_data.head_phase + r_cnt + 3'd1);
                n_fire       = 1'b0;
                n_hold_us    = i_cfg.right_step_us;
                n_last       = (r_cnt == 3'd7);
                n_fired      = 1'b0;
                n_cnt        = r_cnt + 3'd1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_fired <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_q_nonempty;
            if (i_q_nonempty) begin
                r_cnt   <= n_cnt;
                r_fired <= n_fired;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load && i_q_nonempty) begin
            r_action      <= n_action;
            r_head_coils  <= n_head_coils;
            r_paper_coils <= n_paper_coils;
            r_fire        <= n_fire;
            r_hold_us     <= n_hold_us;
            r_need_byte   <= n_need_byte;
            r_refused     <= n_refused;
            r_last        <= n_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_action      = r_action;
    assign o_head_coils  = r_head_coils;
    assign o_paper_coils = r_paper_coils;
    assign o_fire        = r_fire;
    assign o_hold_us     = r_hold_us;
    assign o_need_byte   = r_need_byte;
    assign o_refused     = r_refused;
    assign o_last        = r_last;

endmodule

### dv/raster_dot_printer_sequencer_test.sv
`timescale 1ns / 1ps
// ============================================================================
// raster_dot_printer_sequencer_test
// Self-checking bench for the dot printer sequencer. Start, pixel byte,
// advance and abort items are fed through a valid/stall channel, and random
// gaps and stalls are applied on both sides. An in-bench model of the job,
// head and paper sequencing predicts every result of each accepted item,
// and the monitor compares results field by field in order. Registers are
// rewritten only after the engine has drained, sometimes in the middle of a job.
// ============================================================================
module raster_dot_printer_sequencer_test
    import rdp_pkg::*;
;

    // item kinds
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_PIXEL   = 2'd1;
    localparam logic [1:0] KIND_ADVANCE = 2'd2;
    localparam logic [1:0] KIND_ABORT   = 2'd3;

    // register indexes
    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_RIGHT  = 3'd2;
    localparam logic [2:0] CFG_LEFT   = 3'd3;
    localparam logic [2:0] CFG_PULSE  = 3'd4;
    localparam logic [2:0] CFG_SPARE  = 3'd7;

    // motion constants of the engine
    localparam logic [10:0] LOAD_STEPS     = 11'd100;
    localparam logic [10:0] ROW_FEED_STEPS = 11'd3;
    localparam logic [14:0] PAPER_HOLD     = 15'd4000;
    localparam logic [14:0] MAX_STEP_US    = 15'd25500;
    localparam logic [14:0] MAX_PULSE_US   = 15'd2550;

    // half-step coil patterns, phase 0 in the low nibble
    localparam logic [31:0] HALF_STEP_COILS =
        {4'd9, 4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1};

    localparam int SETTLE_CYCLES   = 20;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_ITEMS    = 60;

    typedef enum logic [2:0] {
        JOB_IDLE, JOB_LOAD, JOB_SWEEP_R, JOB_SWEEP_L,
        JOB_ROW_FEED, JOB_BYTES, JOB_RETURN, JOB_FINISH
    } t_job_phase;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  head_coils;
        logic [3:0]  paper_coils;
        logic        fire;
        logic [14:0] hold_us;
        logic        need_byte;
        logic        refused;
        logic        last;
    } t_dot_action;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] pixel;
        logic [4:0] n_results;
    } t_print_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_kind = '0;
    logic [7:0]  i_pixel_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_action;
    logic [3:0]  o_head_coils;
    logic [3:0]  o_paper_coils;
    logic        o_fire;
    logic [14:0] o_hold_us;
    logic        o_need_byte;
    logic        o_refused;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [14:0] i_cfg_data = '0;

    raster_dot_printer_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_pixel_byte  (i_pixel_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_action      (o_action),
        .o_head_coils  (o_head_coils),
        .o_paper_coils (o_paper_coils),
        .o_fire        (o_fire),
        .o_hold_us     (o_hold_us),
        .o_need_byte   (o_need_byte),
        .o_refused     (o_refused),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // items waiting to be sent, their predicted results, results owed by the engine
    t_print_item queued_items[$];
    t_dot_action staged_actions[$];
    t_dot_action awaited_actions[$];
    t_dot_action batch[$];

    int mismatches = 0;

    // engine model: registers
    logic [7:0]  cfg_width  = 8'd0;
    logic [11:0] cfg_height = 12'd0;
    logic [14:0] cfg_right  = 15'd3000;
    logic [14:0] cfg_left   = 15'd1800;
    logic [11:0] cfg_pulse  = 12'd40;

    // engine model: job and motor state
    t_job_phase  job_ph       = JOB_IDLE;
    logic [10:0] moves_left   = '0;
    logic [7:0]  bytes_in_row = '0;
    logic [11:0] rows_done    = '0;
    logic [2:0]  head_ph      = 3'd7;
    logic [1:0]  paper_ph     = 2'd0;
    logic        release_owed = 1'b0;
    logic        head_live    = 1'b0;
    logic        paper_live   = 1'b0;

    // result with the coil levels of the current motor state
    function automatic t_dot_action make_action(logic [2:0] act, logic pen,
                                                logic [14:0] hold, logic refused);
        t_dot_action r;
        logic [1:0] last_paper;
        r = '0;
        last_paper = paper_ph - 2'd1;
        r.action = act;
        r.head_coils = head_live ? HALF_STEP_COILS[{head_ph, 2'b00} +: 4] : 4'd0;
        r.paper_coils = paper_live ? (4'b0001 << last_paper) : 4'd0;
        r.fire = pen;
        r.hold_us = hold;
        r.refused = refused;
        return r;
    endfunction

    // phase entry, falling through phases that have nothing to do
    function automatic void enter_phase(t_job_phase target);
        logic [10:0] span;
        logic again;
        span = {cfg_width, 3'b000};
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            release_owed = 1'b0;
            moves_left = '0;
            job_ph = target;
            case (target)
                JOB_LOAD: moves_left = LOAD_STEPS;
                JOB_SWEEP_R: begin
                    if (span == 0) begin
                        target = JOB_SWEEP_L;
                        again = 1'b1;
                    end else begin
                        moves_left = span;
                    end
                end
                JOB_SWEEP_L, JOB_RETURN: begin
                    moves_left = span;
                    if (span == 0) release_owed = 1'b1;
                end
                JOB_ROW_FEED: begin
                    if (rows_done >= cfg_height) begin
                        target = JOB_FINISH;
                        again = 1'b1;
                    end else begin
                        moves_left = ROW_FEED_STEPS;
                    end
                end
                JOB_BYTES: begin
                    bytes_in_row = '0;
                    if (cfg_width == 0) begin
                        target = JOB_RETURN;
                        again = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    endfunction

    function automatic void stop_job();
        head_live = 1'b0;
        paper_live = 1'b0;
        job_ph = JOB_IDLE;
        moves_left = '0;
        bytes_in_row = '0;
        rows_done = '0;
        release_owed = 1'b0;
    endfunction

    function automatic void step_head_right();
        head_ph = head_ph + 3'd1;
        head_live = 1'b1;
        batch.push_back(make_action(ACT_RIGHT, 1'b0, cfg_right, 1'b0));
    endfunction

    // one motor step, release or done for an advance item
    function automatic void advance_motion();
        if (job_ph == JOB_FINISH) begin
            stop_job();
            batch.push_back(make_action(ACT_DONE, 1'b0, 15'd0, 1'b0));
        end else if (job_ph == JOB_SWEEP_R) begin
            step_head_right();
            if (moves_left != 0) moves_left = moves_left - 11'd1;
            if (moves_left == 0) enter_phase(JOB_SWEEP_L);
        end else if (release_owed || moves_left == 0) begin
            if (job_ph == JOB_LOAD || job_ph == JOB_ROW_FEED) paper_live = 1'b0;
            else head_live = 1'b0;
            batch.push_back(make_action(ACT_RELEASE, 1'b0, 15'd0, 1'b0));
            case (job_ph)
                JOB_LOAD:     enter_phase(JOB_SWEEP_R);
                JOB_SWEEP_L:  enter_phase(JOB_ROW_FEED);
                JOB_ROW_FEED: enter_phase(JOB_BYTES);
                default: begin
                    rows_done = rows_done + 12'd1;
                    enter_phase(JOB_ROW_FEED);
                end
            endcase
        end else begin
            if (job_ph == JOB_LOAD || job_ph == JOB_ROW_FEED) begin
                paper_ph = paper_ph + 2'd1;
                paper_live = 1'b1;
                batch.push_back(make_action(ACT_PAPER, 1'b0, PAPER_HOLD, 1'b0));
            end else begin
                head_ph = head_ph - 3'd1;
                head_live = 1'b1;
                batch.push_back(make_action(ACT_LEFT, 1'b0, cfg_left, 1'b0));
            end
            moves_left = moves_left - 11'd1;
            if (moves_left == 0) release_owed = 1'b1;
        end
    endfunction

    // all results of one item, left in batch
    function automatic void sequence_item(logic [1:0] kind, logic [7:0] px);
        batch.delete();
        if (kind == KIND_START && job_ph == JOB_IDLE) begin
            bytes_in_row = '0;
            rows_done = '0;
            enter_phase(JOB_LOAD);
            batch.push_back(make_action(ACT_NONE, 1'b0, 15'd0, 1'b0));
        end else if (kind == KIND_PIXEL && job_ph == JOB_BYTES) begin
            // msb first: pen fires with head coils off, then head steps right
            for (int b = 7; b >= 0; b--) begin
                if (px[b]) begin
                    head_live = 1'b0;
                    batch.push_back(make_action(ACT_FIRE, 1'b1, {3'b000, cfg_pulse}, 1'b0));
                end
                step_head_right();
            end
            bytes_in_row = bytes_in_row + 8'd1;
            if (bytes_in_row >= cfg_width || bytes_in_row == 0) enter_phase(JOB_RETURN);
        end else if (kind == KIND_ADVANCE && job_ph != JOB_IDLE && job_ph != JOB_BYTES) begin
            advance_motion();
        end else if (kind == KIND_ABORT && job_ph != JOB_IDLE) begin
            stop_job();
            batch.push_back(make_action(ACT_DONE, 1'b0, 15'd0, 1'b0));
        end else begin
            batch.push_back(make_action(ACT_NONE, 1'b0, 15'd0, 1'b1));
        end
        foreach (batch[i]) begin
            batch[i].need_byte = (job_ph == JOB_BYTES);
            batch[i].last = (i == batch.size() - 1);
        end
    endfunction

    // idle length: mostly none, some short, a few long, with quiet stretches
    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet != 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 72) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // input driver
    t_print_item sent_item;
    int tx_gap = 0;
    int tx_quiet = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sent_item = queued_items.pop_front();
                repeat (sent_item.n_results)
                    awaited_actions.push_back(staged_actions.pop_front());
                tx_gap = pick_gap(tx_quiet);
            end
            if (!i_valid || !o_stall) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (queued_items.size() != 0) begin
                    i_valid <= 1'b1;
                    i_kind <= queued_items[0].kind;
                    i_pixel_byte <= queued_items[0].pixel;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, started by toggling hold_req
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor and output stall
    t_dot_action want;
    int rx_gap = 0;
    int rx_quiet = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (awaited_actions.size() == 0) begin
                    mismatches++;
                    $error("result with no item pending: action %0d", o_action);
                end else begin
                    want = awaited_actions.pop_front();
                    check_field("action", 16'(want.action), 16'(o_action));
                    check_field("head_coils", 16'(want.head_coils), 16'(o_head_coils));
                    check_field("paper_coils", 16'(want.paper_coils), 16'(o_paper_coils));
                    check_field("fire", 16'(want.fire), 16'(o_fire));
                    check_field("hold_us", 16'(want.hold_us), 16'(o_hold_us));
                    check_field("need_byte", 16'(want.need_byte), 16'(o_need_byte));
                    check_field("refused", 16'(want.refused), 16'(o_refused));
                    check_field("last", 16'(want.last), 16'(o_last));
                end
            end
            if (hold_left != 0) begin
                i_stall <= 1'b1;
            end else if (rx_gap != 0) begin
                rx_gap--;
                i_stall <= 1'b1;
            end else begin
                rx_gap = pick_gap(rx_quiet);
                i_stall <= 1'b0;
            end
        end
    end

    // queue one item with its predicted results
    task automatic push_item(logic [1:0] kind, logic [7:0] pixel);
        t_print_item it;
        while (queued_items.size() >= 8) @(posedge i_clk);
        sequence_item(kind, pixel);
        it.kind = kind;
        it.pixel = pixel;
        it.n_results = 5'(batch.size());
        foreach (batch[i]) staged_actions.push_back(batch[i]);
        queued_items.push_back(it);
    endtask

    // wait until every item is in and every result is out
    task automatic drain();
        while (queued_items.size() != 0 || awaited_actions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [14:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:  cfg_width = value[7:0];
            CFG_HEIGHT: cfg_height = value[11:0];
            CFG_RIGHT:  cfg_right = value;
            CFG_LEFT:   cfg_left = value;
            CFG_PULSE:  cfg_pulse = value[11:0];
            default: ;
        endcase
    endtask

    // advance until the engine wants a byte (optionally) or the job ends
    task automatic run_advances(bit to_bytes);
        while (job_ph != JOB_IDLE && !(to_bytes && job_ph == JOB_BYTES))
            push_item(KIND_ADVANCE, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [14:0] pick_delay(logic [14:0] top);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 15'd0;
        if (r == 1) return top;
        return 15'($urandom_range(0, top));
    endfunction

    // small widths and heights keep jobs short
    function automatic logic [14:0] pick_value(logic [2:0] idx);
        int r;
        r = $urandom_range(0, 9);
        case (idx)
            CFG_WIDTH:  return (r == 0) ? 15'd0 : (r == 9) ? 15'($urandom_range(4, 6))
                                                            : 15'($urandom_range(1, 3));
            CFG_HEIGHT: return 15'($urandom_range(0, 3));
            CFG_RIGHT,
            CFG_LEFT:   return pick_delay(MAX_STEP_US);
            CFG_PULSE:  return pick_delay(MAX_PULSE_US);
            default:    return 15'd0;
        endcase
    endfunction

    function automatic logic [7:0] pick_pixel();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // stimulus
    int good_items = 0;
    logic [1:0] next_kind;
    logic [2:0] reg_idx;
    logic noise;

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wrong items while idle
        push_item(KIND_PIXEL, 8'hA5);
        push_item(KIND_ADVANCE, 8'h5A);
        push_item(KIND_ABORT, 8'h00);

        // default registers: zero width and zero height, start while running
        push_item(KIND_START, 8'hFF);
        push_item(KIND_START, 8'h00);
        run_advances(1'b0);
        drain();

        // one row of two bytes, extreme hold times
        write_reg(CFG_WIDTH, 15'd2);
        write_reg(CFG_HEIGHT, 15'd1);
        write_reg(CFG_RIGHT, 15'd0);
        write_reg(CFG_LEFT, MAX_STEP_US);
        write_reg(CFG_PULSE, MAX_PULSE_US);
        push_item(KIND_START, 8'h3C);
        run_advances(1'b1);
        push_item(KIND_PIXEL, 8'hFF);
        push_item(KIND_ADVANCE, 8'h00);
        push_item(KIND_START, 8'h00);

        // width lowered to the count of bytes already taken; the next byte ends the row
        drain();
        write_reg(CFG_WIDTH, 15'd1);
        write_reg(CFG_RIGHT, MAX_STEP_US);
        push_item(KIND_PIXEL, 8'h00);
        run_advances(1'b0);
        drain();

        // largest width and a large height, cut short by abort; spare index write is dropped
        write_reg(CFG_WIDTH, 15'd255);
        write_reg(CFG_HEIGHT, 15'd2295);
        write_reg(CFG_PULSE, 15'd0);
        write_reg(CFG_LEFT, 15'd0);
        write_reg(CFG_SPARE, 15'h7FFF);
        push_item(KIND_START, 8'h81);
        repeat (105) push_item(KIND_ADVANCE, 8'($urandom_range(0, 255)));
        push_item(KIND_ABORT, 8'h7E);
        push_item(KIND_ABORT, 8'h18);
        drain();

        // random jobs with noise and the occasional abort
        while (good_items < RANDOM_ITEMS) begin
            noise = ($urandom_range(0, 11) == 0);
            if (job_ph == JOB_IDLE && !noise && $urandom_range(0, 1) == 0) begin
                drain();
                for (int r = 0; r < 5; r++) write_reg(r[2:0], pick_value(r[2:0]));
            end else if (job_ph != JOB_IDLE && $urandom_range(0, 199) == 0) begin
                // live register change mid-job
                drain();
                reg_idx = 3'($urandom_range(0, 4));
                write_reg(reg_idx, pick_value(reg_idx));
            end
            if (noise) begin
                next_kind = 2'($urandom_range(0, 3));
                if (next_kind == KIND_ABORT && job_ph != JOB_IDLE) next_kind = KIND_START;
            end else if (job_ph != JOB_IDLE && $urandom_range(0, 399) == 0) begin
                next_kind = KIND_ABORT;
            end else begin
                case (job_ph)
                    JOB_IDLE:  next_kind = KIND_START;
                    JOB_BYTES: next_kind = KIND_PIXEL;
                    default:   next_kind = KIND_ADVANCE;
                endcase
            end
            push_item(next_kind, pick_pixel());
            if (!batch[0].refused) begin
                good_items++;
                if (good_items == 10 || good_items == 40) hold_req <= ~hold_req;
            end
        end

        while (queued_items.size() != 0 || awaited_actions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial begin
        #100ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### raster_dot_printer_sequencer.f
hw/rtl/rdp_pkg.sv
hw/rtl/rdp_queue.sv
hw/rtl/rdp_front.sv
hw/rtl/rdp_back.sv
hw/rtl/raster_dot_printer_sequencer.sv
dv/raster_dot_printer_sequencer_test.sv
